### design/iskm_pkg.sv
// Package for the I2C slave key matrix reporter.
// Holds matrix sizes, protocol phase codes, the key packing function and the
// control struct passed to the key store. No dependencies.
package iskm_pkg;

	localparam int COLUMNS   = 6;
	localparam int ROWS_N    = 5;
	localparam int KEY_BYTES = 4;

	// Row levels input is fixed by the bus format
	localparam int PIN_W    = 30;
	localparam int KEY_BITS = KEY_BYTES * 8;
	localparam int KIDX_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int SIDX_W   = $clog2(KEY_BYTES + 1);
	localparam int ADDR_W   = 7;
	localparam int PHASE_W  = 3;

	localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 7'd8;

	// Operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_PHASE = 1'b1;

	// Protocol phase codes
	localparam logic [PHASE_W-1:0] PH_ADDRESS  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ACK_WR   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RECEIVE  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ACK_RD   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_WAIT_ACK = 3'd4;
	localparam logic [PHASE_W-1:0] PH_TRANSMIT = 3'd5;

	// Control from the protocol engine to the key store
	typedef struct packed {
		logic              update;
		logic              capture;
		logic [KIDX_W-1:0] rd_index;
	} key_ctrl_t;

	// Pack active-low pin levels into row-major key bits.
	// Key row*COLUMNS+col comes from pin col*ROWS_N+row; bits no key covers hold.
	function automatic logic [KEY_BITS-1:0] pack_keys(
		input logic [KEY_BITS-1:0] old_bits,
		input logic [PIN_W-1:0]    levels
	);
		logic [KEY_BITS-1:0] res;
		int key;
		int pin;
		res = old_bits;
		for (int col = 0; col < COLUMNS; col++) begin
			for (int row = 0; row < ROWS_N; row++) begin
				key = row * COLUMNS + col;
				pin = col * ROWS_N + row;
				if (key < KEY_BITS && pin < PIN_W) begin
					res[key] = ~levels[pin];
				end
			end
		end
		return res;
	endfunction

endpackage

### design/iskm_if.sv
// Valid/ready channel interfaces for the key matrix reporter.
// One for bus event items, one for result items; uses iskm_pkg widths.
interface iskm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [7:0]                  bus_byte;
	logic [iskm_pkg::PIN_W-1:0]  row_levels;

	modport source (output valid, output operation, output bus_byte, output row_levels,
		input ready);
	modport sink (input valid, input operation, input bus_byte, input row_levels,
		output ready);
endinterface

interface iskm_out_if;
	logic                          valid;
	logic                          ready;
	logic [iskm_pkg::PHASE_W-1:0]  protocol_state;
	logic                          is_listening;
	logic                          sda_enable;
	logic                          sda_level;
	logic                          ack_phase;
	logic                          tx_load;
	logic [7:0]                    tx_byte;

	modport source (output valid, output protocol_state, output is_listening,
		output sda_enable, output sda_level, output ack_phase, output tx_load,
		output tx_byte, input ready);
	modport sink (input valid, input protocol_state, input is_listening,
		input sda_enable, input sda_level, input ack_phase, input tx_load,
		input tx_byte, output ready);
endinterface

### design/iskm_keys.sv
// Key byte store for the key matrix reporter.
// Captures the matrix into packed bytes and reads one byte; uses iskm_pkg.
module iskm_keys (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iskm_pkg::key_ctrl_t        ctrl,
	input  logic [iskm_pkg::PIN_W-1:0] levels,
	output logic [7:0]                 rd_byte
);

	logic [iskm_pkg::KEY_BITS-1:0] key_q;
	logic [iskm_pkg::KEY_BITS-1:0] packed_bits;
	logic [iskm_pkg::KEY_BITS-1:0] src_bits;
	logic [7:0]                    src_bytes [iskm_pkg::KEY_BYTES];

	// Freshly captured bits are visible to the read in the same step
	assign packed_bits = iskm_pkg::pack_keys(key_q, levels);
	assign src_bits    = ctrl.capture ? packed_bits : key_q;

	always_comb begin
		for (int b = 0; b < iskm_pkg::KEY_BYTES; b++) begin
			src_bytes[b] = src_bits[b*8 +: 8];
		end
	end

	assign rd_byte = src_bytes[ctrl.rd_index];

	// Hold key bytes until an advancing item in the read ack phase captures new levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (ctrl.update && ctrl.capture) begin
			key_q <= packed_bits;
		end
	end

endmodule

### design/i2c_slave_key_matrix_reporter.sv
// Byte-level I2C slave that reports a key matrix: top level.
// An accepted item passes through the input register, then the result register,
// where it is held until taken; a result held there stalls the item behind it.
// Throughput: one item per cycle otherwise; the protocol state update is a single step.
// The output register lets a new item enter while a result waits to be taken.
// Reset (arst_n low, asynchronous): address phase, not listening, SDA released,
// key bytes cleared, own address 8.
module i2c_slave_key_matrix_reporter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [iskm_pkg::ADDR_W-1:0] cfg_write_data,
	iskm_in_if.sink                     item_in,
	iskm_out_if.source                  result_out
);

	// Configuration
	logic [iskm_pkg::ADDR_W-1:0] own_address_q;

	// Input stage
	logic                       valid_s1;
	logic                       op_s1;
	logic [7:0]                 byte_s1;
	logic [iskm_pkg::PIN_W-1:0] levels_s1;

	// Protocol state
	logic [iskm_pkg::PHASE_W-1:0] phase_q;
	logic                         listen_q;
	logic                         drive_q;
	logic                         high_q;
	logic [iskm_pkg::SIDX_W-1:0]  send_idx_q;

	// Result stage
	logic                         out_valid_q;
	logic [iskm_pkg::PHASE_W-1:0] res_phase_q;
	logic                         res_listen_q;
	logic                         res_drive_q;
	logic                         res_high_q;
	logic                         res_ack_q;
	logic                         res_load_q;
	logic [7:0]                   res_byte_q;

	// Next-state logic
	logic [iskm_pkg::PHASE_W-1:0] phase_nxt;
	logic                         listen_nxt;
	logic                         drive_nxt;
	logic                         high_nxt;
	logic [iskm_pkg::SIDX_W-1:0]  send_idx_nxt;
	logic                         ack;
	logic                         load;
	logic [7:0]                   txb;
	logic                         capture;
	logic                         idx_in_range;
	logic [7:0]                   rd_byte;
	logic                         advance;
	iskm_pkg::key_ctrl_t          key_ctrl;

	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign idx_in_range  = send_idx_q < iskm_pkg::SIDX_W'(iskm_pkg::KEY_BYTES);

	// Own address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= iskm_pkg::OWN_ADDRESS_RESET;
		end else if (cfg_write_en) begin
			own_address_q <= cfg_write_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			op_s1     <= item_in.operation;
			byte_s1   <= item_in.bus_byte;
			levels_s1 <= item_in.row_levels;
		end
	end

	// Advance the protocol one step for the item in the input register
	always_comb begin
		phase_nxt    = phase_q;
		listen_nxt   = listen_q;
		drive_nxt    = drive_q;
		high_nxt     = high_q;
		send_idx_nxt = send_idx_q;
		ack          = 1'b0;
		load         = 1'b0;
		capture      = 1'b0;
		if (op_s1 == iskm_pkg::OP_START) begin
			phase_nxt  = iskm_pkg::PH_ADDRESS;
			listen_nxt = 1'b1;
		end else if (listen_q) begin
			case (phase_q)
				iskm_pkg::PH_ADDRESS: begin
					if (byte_s1[7:1] != own_address_q) begin
						listen_nxt = 1'b0;
					end else begin
						drive_nxt = 1'b1;
						ack       = 1'b1;
						phase_nxt = byte_s1[0] ? iskm_pkg::PH_ACK_RD : iskm_pkg::PH_ACK_WR;
					end
				end
				iskm_pkg::PH_ACK_WR: begin
					drive_nxt = 1'b0;
					phase_nxt = iskm_pkg::PH_RECEIVE;
				end
				iskm_pkg::PH_RECEIVE: begin
					drive_nxt = 1'b1;
					ack       = 1'b1;
					phase_nxt = iskm_pkg::PH_ACK_WR;
				end
				iskm_pkg::PH_ACK_RD: begin
					// Capture the matrix and send the first byte
					capture      = 1'b1;
					load         = 1'b1;
					high_nxt     = 1'b1;
					send_idx_nxt = iskm_pkg::SIDX_W'(1);
					phase_nxt    = iskm_pkg::PH_TRANSMIT;
				end
				iskm_pkg::PH_WAIT_ACK: begin
					if (byte_s1[0]) begin
						// Master NACK ends the transfer
						phase_nxt = iskm_pkg::PH_ADDRESS;
					end else begin
						load      = 1'b1;
						high_nxt  = 1'b1;
						drive_nxt = 1'b1;
						phase_nxt = iskm_pkg::PH_TRANSMIT;
						if (idx_in_range) begin
							send_idx_nxt = send_idx_q + iskm_pkg::SIDX_W'(1);
						end
					end
				end
				iskm_pkg::PH_TRANSMIT: begin
					drive_nxt = 1'b0;
					high_nxt  = 1'b0;
					ack       = 1'b1;
					phase_nxt = iskm_pkg::PH_WAIT_ACK;
				end
				default: begin
				end
			endcase
		end
	end

	// Read byte zero on capture, else the current send index; past the end sends zero
	assign key_ctrl.update   = advance;
	assign key_ctrl.capture  = capture;
	assign key_ctrl.rd_index = capture ? '0 : send_idx_q[iskm_pkg::KIDX_W-1:0];

	iskm_keys u_keys (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (key_ctrl),
		.levels  (levels_s1),
		.rd_byte (rd_byte)
	);

	always_comb begin
		txb = 8'h00;
		if (load && (capture || idx_in_range)) begin
			txb = rd_byte;
		end
	end

	// Commit state and result together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= iskm_pkg::PH_ADDRESS;
			listen_q    <= 1'b0;
			drive_q     <= 1'b0;
			high_q      <= 1'b0;
			send_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_nxt;
			listen_q    <= listen_nxt;
			drive_q     <= drive_nxt;
			high_q      <= high_nxt;
			send_idx_q  <= send_idx_nxt;
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_phase_q  <= phase_nxt;
			res_listen_q <= listen_nxt;
			res_drive_q  <= drive_nxt;
			res_high_q   <= high_nxt;
			res_ack_q    <= ack;
			res_load_q   <= load;
			res_byte_q   <= txb;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.protocol_state = res_phase_q;
	assign result_out.is_listening   = res_listen_q;
	assign result_out.sda_enable     = res_drive_q;
	assign result_out.sda_level      = res_high_q;
	assign result_out.ack_phase      = res_ack_q;
	assign result_out.tx_load        = res_load_q;
	assign result_out.tx_byte        = res_byte_q;

endmodule

### test/i2c_slave_key_matrix_reporter_test.sv
// Testbench for the I2C slave key matrix reporter: drives bus event items,
// predicts each result item from its own protocol model and checks them in order.
// Depends on iskm_pkg, the iskm_in_if/iskm_out_if interfaces and the top level.
module i2c_slave_key_matrix_reporter_test;

	typedef struct packed {
		logic [iskm_pkg::PHASE_W-1:0] state;
		logic                         listening;
		logic                         sda_en;
		logic                         sda_lvl;
		logic                         ack;
		logic                         load;
		logic [7:0]                   txb;
	} bus_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write_en;
	logic [iskm_pkg::ADDR_W-1:0]   cfg_write_data;

	iskm_in_if  item_if ();
	iskm_out_if result_if ();

	i2c_slave_key_matrix_reporter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.item_in       (item_if),
		.result_out    (result_if)
	);

	// Protocol model state
	logic [iskm_pkg::PHASE_W-1:0]  ph;
	logic                          listening;
	logic                          sda_drive;
	logic                          sda_hi;
	logic [7:0]                    key_store [iskm_pkg::KEY_BYTES];
	int                            tx_index;
	logic [iskm_pkg::ADDR_W-1:0]   own_addr;

	bus_result_t         pending_results [$];
	int                  error_count;
	int                  items_sent;
	bit                  snd_idle;
	bit                  rcv_idle;
	int                  hold_off;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned exp_v,
		input int unsigned got_v);
		if (error_count < 40)
			$display("mismatch %0s: expected %0h got %0h", what, exp_v, got_v);
		error_count++;
	endtask

	// Take the next key byte; hold at the end and read zero past it
	function automatic logic [7:0] next_tx_byte();
		logic [7:0] b;
		b = 8'h00;
		if (tx_index < iskm_pkg::KEY_BYTES) begin
			b = key_store[tx_index];
			tx_index++;
		end
		return b;
	endfunction

	// Advance the protocol model by one item and return the result it causes
	function automatic bus_result_t predict_bus_step(input logic op, input logic [7:0] b,
		input logic [iskm_pkg::PIN_W-1:0] lv);
		bus_result_t r;
		int k;
		r = '0;
		if (op == iskm_pkg::OP_START) begin
			ph = iskm_pkg::PH_ADDRESS;
			listening = 1'b1;
		end else if (listening) begin
			case (ph)
				iskm_pkg::PH_ADDRESS: begin
					if (b[7:1] != own_addr) begin
						listening = 1'b0;
					end else begin
						sda_drive = 1'b1;
						r.ack = 1'b1;
						ph = b[0] ? iskm_pkg::PH_ACK_RD : iskm_pkg::PH_ACK_WR;
					end
				end
				iskm_pkg::PH_ACK_WR: begin
					sda_drive = 1'b0;
					ph = iskm_pkg::PH_RECEIVE;
				end
				iskm_pkg::PH_RECEIVE: begin
					sda_drive = 1'b1;
					r.ack = 1'b1;
					ph = iskm_pkg::PH_ACK_WR;
				end
				iskm_pkg::PH_ACK_RD: begin
					// Capture active-low pins into row-major key bits
					for (int c = 0; c < iskm_pkg::COLUMNS; c++) begin
						for (int rw = 0; rw < iskm_pkg::ROWS_N; rw++) begin
							k = rw * iskm_pkg::COLUMNS + c;
							if (k < iskm_pkg::KEY_BYTES * 8)
								key_store[k / 8][k % 8] = ~lv[c * iskm_pkg::ROWS_N + rw];
						end
					end
					tx_index = 0;
					r.txb = next_tx_byte();
					r.load = 1'b1;
					sda_hi = 1'b1;
					ph = iskm_pkg::PH_TRANSMIT;
				end
				iskm_pkg::PH_WAIT_ACK: begin
					if (b[0]) begin
						ph = iskm_pkg::PH_ADDRESS;
					end else begin
						r.txb = next_tx_byte();
						r.load = 1'b1;
						sda_hi = 1'b1;
						sda_drive = 1'b1;
						ph = iskm_pkg::PH_TRANSMIT;
					end
				end
				iskm_pkg::PH_TRANSMIT: begin
					sda_drive = 1'b0;
					sda_hi = 1'b0;
					r.ack = 1'b1;
					ph = iskm_pkg::PH_WAIT_ACK;
				end
				default: begin
				end
			endcase
		end
		r.state = ph;
		r.listening = listening;
		r.sda_en = sda_drive;
		r.sda_lvl = sda_hi;
		return r;
	endfunction

	// Offer one item after a random gap, wait for accept, queue its prediction
	task automatic send_item(input logic op, input logic [7:0] b,
		input logic [iskm_pkg::PIN_W-1:0] lv);
		int gap;
		gap = snd_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.operation <= op;
		item_if.bus_byte <= b;
		item_if.row_levels <= lv;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		pending_results.push_back(predict_bus_step(op, b, lv));
		items_sent++;
	endtask

	function automatic logic [iskm_pkg::PIN_W-1:0] rand_levels();
		logic [iskm_pkg::PIN_W-1:0] v;
		v = iskm_pkg::PIN_W'($urandom());
		return v;
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [7:0] v;
		v = 8'($urandom());
		return v;
	endfunction

	// Master ack byte: bit 0 high means NACK, other bits are noise
	function automatic logic [7:0] ack_byte(input bit nack);
		logic [7:0] v;
		v = 8'($urandom());
		v[0] = nack;
		return v;
	endfunction

	task automatic send_start();
		send_item(iskm_pkg::OP_START, rand_byte(), rand_levels());
	endtask

	task automatic send_phase(input logic [7:0] b);
		send_item(iskm_pkg::OP_PHASE, b, rand_levels());
	endtask

	// Drop valid and wait until every result has come back
	task automatic wait_drain();
		item_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_address(input logic [iskm_pkg::ADDR_W-1:0] a);
		wait_drain();
		cfg_write_en <= 1'b1;
		cfg_write_data <= a;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		own_addr = a;
		@(posedge clk);
	endtask

	// Full read transfer: address, capture, nbytes sent, NACK on the last
	task automatic run_read(input logic [iskm_pkg::ADDR_W-1:0] a, input int nbytes,
		input logic [iskm_pkg::PIN_W-1:0] lv);
		send_start();
		send_phase({a, 1'b1});
		send_item(iskm_pkg::OP_PHASE, rand_byte(), lv);
		for (int i = 0; i < nbytes; i++) begin
			send_phase(rand_byte());
			send_phase(ack_byte(i == nbytes - 1));
		end
	endtask

	// Full write transfer: address, then nbytes acknowledged and dropped
	task automatic run_write(input logic [iskm_pkg::ADDR_W-1:0] a, input int nbytes);
		send_start();
		send_phase({a, 1'b0});
		for (int i = 0; i < nbytes; i++) begin
			send_phase(rand_byte());
			send_phase(rand_byte());
		end
	endtask

	// Check each accepted result; draw a wait per item, honor long hold-offs
	initial begin
		bus_result_t got;
		bus_result_t exp;
		int wait_left;
		wait_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready) begin
				got.state = result_if.protocol_state;
				got.listening = result_if.is_listening;
				got.sda_en = result_if.sda_enable;
				got.sda_lvl = result_if.sda_level;
				got.ack = result_if.ack_phase;
				got.load = result_if.tx_load;
				got.txb = result_if.tx_byte;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", 0, 32'(got));
				end else begin
					exp = pending_results.pop_front();
					if (got.state !== exp.state)
						report_mismatch("protocol_state", exp.state, got.state);
					if (got.listening !== exp.listening)
						report_mismatch("is_listening", exp.listening, got.listening);
					if (got.sda_en !== exp.sda_en)
						report_mismatch("sda_enable", exp.sda_en, got.sda_en);
					if (got.sda_lvl !== exp.sda_lvl)
						report_mismatch("sda_level", exp.sda_lvl, got.sda_lvl);
					if (got.ack !== exp.ack)
						report_mismatch("ack_phase", exp.ack, got.ack);
					if (got.load !== exp.load)
						report_mismatch("tx_load", exp.load, got.load);
					if (got.txb !== exp.txb)
						report_mismatch("tx_byte", exp.txb, got.txb);
				end
				wait_left = rcv_idle ? $urandom_range(0, 4) : 0;
			end
			if (hold_off > 0) begin
				hold_off--;
				result_if.ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Idle completions, address mismatch, both paths, pin extremes, read past end
	task automatic test_default_address();
		send_phase(8'hFF);
		send_start();
		send_phase(8'h00);
		send_phase({iskm_pkg::OWN_ADDRESS_RESET, 1'b1});
		send_start();
		send_phase({iskm_pkg::OWN_ADDRESS_RESET, 1'b0});
		send_phase(8'h00);
		send_phase(8'hFF);
		send_phase(8'hFF);
		send_phase(8'h00);
		run_read(iskm_pkg::OWN_ADDRESS_RESET, 5, '0);
		run_read(iskm_pkg::OWN_ADDRESS_RESET, 2, '1);
	endtask

	// Start in the middle of a transmit keeps SDA driven
	task automatic test_start_mid_transfer();
		send_start();
		send_phase({own_addr, 1'b1});
		send_item(iskm_pkg::OP_PHASE, 8'hA5, 30'h2AAAAAAA);
		send_start();
		send_phase({own_addr, 1'b0});
		send_phase(rand_byte());
		send_start();
		send_phase({own_addr ^ 7'h40, 1'b1});
		send_phase(rand_byte());
	endtask

	task automatic test_address_settings();
		logic [iskm_pkg::ADDR_W-1:0] list [3];
		list[0] = '0;
		list[1] = '1;
		list[2] = iskm_pkg::ADDR_W'($urandom());
		foreach (list[i]) begin
			set_address(list[i]);
			run_read(list[i], 2, rand_levels());
			run_write(list[i], 1);
			send_start();
			send_phase({list[i] ^ 7'h01, 1'b0});
		end
		set_address(iskm_pkg::OWN_ADDRESS_RESET);
	endtask

	// Long receiver hold-off with the sender pushing, then a sender pause
	task automatic test_pressure();
		snd_idle = 1'b0;
		hold_off = 60;
		run_read(own_addr, 6, rand_levels());
		run_write(own_addr, 6);
		snd_idle = 1'b1;
		send_start();
		send_phase({own_addr, 1'b1});
		send_item(iskm_pkg::OP_PHASE, rand_byte(), rand_levels());
		send_phase(rand_byte());
		wait_drain();
		send_phase(ack_byte(1'b0));
		send_phase(rand_byte());
		send_phase(ack_byte(1'b1));
	endtask

	// Mostly well-formed transfers with random content, some noise and aborts
	task automatic test_random_transfers(input int count);
		int first;
		int kind;
		logic [iskm_pkg::ADDR_W-1:0] other;
		first = items_sent;
		while (items_sent - first < count) begin
			snd_idle = ($urandom_range(0, 3) != 0);
			rcv_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 24) == 0)
				set_address(iskm_pkg::ADDR_W'($urandom()));
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					if ($urandom_range(0, 4) == 0)
						run_read(own_addr, $urandom_range(4, 6), rand_levels());
					else
						run_read(own_addr, $urandom_range(1, 3), rand_levels());
				end
				4, 5, 6: begin
					run_write(own_addr, $urandom_range(0, 4));
				end
				7: begin
					other = own_addr ^ 7'($urandom_range(1, 127));
					send_start();
					send_phase({other, 1'($urandom_range(0, 1))});
					repeat ($urandom_range(0, 3)) send_phase(rand_byte());
				end
				8: begin
					repeat ($urandom_range(1, 5))
						send_item(1'($urandom_range(0, 1)), rand_byte(), rand_levels());
				end
				default: begin
					// Broken read: stop after a few bytes without a NACK
					send_start();
					send_phase({own_addr, 1'b1});
					send_item(iskm_pkg::OP_PHASE, rand_byte(), rand_levels());
					repeat ($urandom_range(0, 3)) begin
						send_phase(rand_byte());
						send_phase(ack_byte(1'b0));
					end
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		item_if.valid <= 1'b0;
		item_if.operation <= iskm_pkg::OP_START;
		item_if.bus_byte <= '0;
		item_if.row_levels <= '0;
		ph = iskm_pkg::PH_ADDRESS;
		listening = 1'b0;
		sda_drive = 1'b0;
		sda_hi = 1'b0;
		foreach (key_store[i]) key_store[i] = '0;
		tx_index = 0;
		own_addr = iskm_pkg::OWN_ADDRESS_RESET;
		error_count = 0;
		items_sent = 0;
		snd_idle = 1'b1;
		rcv_idle = 1'b1;
		hold_off = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_address();
		test_start_mid_transfer();
		test_address_settings();
		test_pressure();
		test_random_transfers(340);

		wait_drain();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
